/* rtl/frg_pkg.sv */
// Shared types and constants of the message fragmenter and framer.
package frg_pkg;

  // Header bytes in front of each fragment
  localparam int HeaderBytes = 9;
  localparam int HdrCntBits  = $clog2(HeaderBytes);
  // Widest message length that a queued request can carry
  localparam int LenMaxBits  = 32;
  // Fragment payload size after reset
  localparam logic [15:0] MssReset = 16'd1024;

  typedef enum logic {
    OP_START = 1'b0,
    OP_BYTE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MSS_ZERO = 2'd1,
    ST_TOO_MANY = 2'd2,
    ST_STRAY    = 2'd3
  } status_e;

  // Classified request handed from the front to the back
  typedef enum logic [1:0] {
    CMD_ERROR = 2'd0,
    CMD_START = 2'd1,
    CMD_EMPTY = 2'd2,
    CMD_BYTE  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e                  cmd;
    status_e               status;
    logic [31:0]           session;
    logic [15:0]           packet;
    logic [LenMaxBits-1:0] len;
    logic [15:0]           mss;
    logic [7:0]            nfrags;
    logic [7:0]            data;
  } cmd_t;

  typedef enum logic [1:0] {
    FS_IDLE   = 2'd0,
    FS_CHECK  = 2'd1,
    FS_DIVIDE = 2'd2,
    FS_PUSH   = 2'd3
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE   = 2'd0,
    BS_HEADER = 2'd1,
    BS_DATA   = 2'd2
  } back_state_e;

endpackage

/* rtl/frg_in_if.sv */
// Input request channel: start or payload byte.
interface frg_in_if #(
  parameter int LEN_BITS = 24
);
  logic                valid;
  logic                ready;
  logic                op;
  logic [31:0]         sess_id;
  logic [15:0]         pkt_id;
  logic [LEN_BITS-1:0] msg_len;
  logic [7:0]          data_byte;

  modport source (output valid, op, sess_id, pkt_id, msg_len, data_byte,
                  input ready);
  modport sink   (input valid, op, sess_id, pkt_id, msg_len, data_byte,
                  output ready);
endinterface

/* rtl/frg_out_if.sv */
// Output result channel: status, header byte or payload byte.
interface frg_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [7:0] frag_index;
  logic       frag_end;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, out_byte, frag_index, frag_end, status, last,
                  input ready);
  modport sink   (input valid, kind, out_byte, frag_index, frag_end, status, last,
                  output ready);
endinterface

/* rtl/frg_cmd_fifo.sv */
// Two-entry request queue between the front and the back.
module frg_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frg_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  output logic          head_valid_o,
  output frg_pkg::cmd_t head_cmd_o,
  input  logic          pop_i
);

  frg_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_cmd_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/frg_front.sv */
// Front end: accepts requests, checks starts and counts fragments.
module frg_front #(
  parameter int LEN_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  frg_in_if.sink        req_i,
  input  logic [15:0]   mss_i,
  output logic          push_o,
  output frg_pkg::cmd_t push_cmd_o,
  input  logic          full_i
);

  localparam int DivW = (LEN_BITS > 24) ? LEN_BITS : 24;

  frg_pkg::front_state_e state_q, state_d;
  logic [31:0]           session_q, session_d;
  logic [15:0]           packet_q, packet_d;
  logic [LEN_BITS-1:0]   len_q, len_d;
  logic [15:0]           mss_q, mss_d;
  logic [DivW-1:0]       rem_q, rem_d;
  logic [7:0]            quo_q, quo_d;
  logic [2:0]            step_q, step_d;

  logic                  accept;
  logic                  is_start;
  logic [23:0]           limit;
  logic                  len_zero;
  logic                  too_many;
  logic [DivW-1:0]       trial;
  logic                  trial_fits;

  assign req_i.ready = (state_q == frg_pkg::FS_IDLE) && !full_i;
  assign accept      = req_i.valid && req_i.ready;
  assign is_start    = (req_i.op == frg_pkg::OP_START);

  // Largest length that still fits in 255 fragments: 255 * mss
  assign limit      = {mss_q, 8'h00} - {8'h00, mss_q};
  assign len_zero   = (len_q == '0);
  assign too_many   = (DivW'(len_q) > DivW'(limit));
  // Restoring divide, one quotient bit per cycle
  assign trial      = DivW'(mss_q) << step_q;
  assign trial_fits = (rem_q >= trial);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frg_pkg::FS_IDLE: begin
        if (accept && is_start && (mss_i != 16'd0)) begin
          state_d = frg_pkg::FS_CHECK;
        end
      end
      frg_pkg::FS_CHECK: begin
        if (!full_i) begin
          state_d = (len_zero || too_many) ? frg_pkg::FS_IDLE : frg_pkg::FS_DIVIDE;
        end
      end
      frg_pkg::FS_DIVIDE: begin
        if (step_q == 3'd0) begin
          state_d = frg_pkg::FS_PUSH;
        end
      end
      frg_pkg::FS_PUSH: begin
        if (!full_i) begin
          state_d = frg_pkg::FS_IDLE;
        end
      end
      default: state_d = frg_pkg::FS_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    push_o     = 1'b0;
    push_cmd_o = '{
      cmd:     frg_pkg::CMD_BYTE,
      status:  frg_pkg::ST_OK,
      session: session_q,
      packet:  packet_q,
      len:     frg_pkg::LenMaxBits'(len_q),
      mss:     mss_q,
      nfrags:  quo_q,
      data:    req_i.data_byte
    };
    session_d = session_q;
    packet_d  = packet_q;
    len_d     = len_q;
    mss_d     = mss_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    unique case (state_q)
      frg_pkg::FS_IDLE: begin
        if (accept) begin
          if (!is_start) begin
            push_o = 1'b1;
          end else if (mss_i == 16'd0) begin
            push_o            = 1'b1;
            push_cmd_o.cmd    = frg_pkg::CMD_ERROR;
            push_cmd_o.status = frg_pkg::ST_MSS_ZERO;
          end else begin
            session_d = req_i.sess_id;
            packet_d  = req_i.pkt_id;
            len_d     = req_i.msg_len;
            mss_d     = mss_i;
          end
        end
      end
      frg_pkg::FS_CHECK: begin
        rem_d  = DivW'(len_q);
        quo_d  = 8'd0;
        step_d = 3'd7;
        if (!full_i) begin
          if (len_zero) begin
            push_o         = 1'b1;
            push_cmd_o.cmd = frg_pkg::CMD_EMPTY;
          end else if (too_many) begin
            push_o            = 1'b1;
            push_cmd_o.cmd    = frg_pkg::CMD_ERROR;
            push_cmd_o.status = frg_pkg::ST_TOO_MANY;
          end
        end
      end
      frg_pkg::FS_DIVIDE: begin
        if (trial_fits) begin
          rem_d         = rem_q - trial;
          quo_d[step_q] = 1'b1;
        end
        step_d = step_q - 3'd1;
      end
      frg_pkg::FS_PUSH: begin
        // Round up when a partial fragment remains
        push_cmd_o.cmd    = frg_pkg::CMD_START;
        push_cmd_o.nfrags = quo_q + {7'd0, (rem_q != '0)};
        push_o            = !full_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frg_pkg::FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    session_q <= session_d;
    packet_q  <= packet_d;
    len_q     <= len_d;
    mss_q     <= mss_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    step_q    <= step_d;
  end

endmodule

/* rtl/frg_back.sv */
// Back end: keeps message state, emits status, header and payload results.
module frg_back #(
  parameter int LEN_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  frg_pkg::cmd_t head_cmd_i,
  output logic          pop_o,
  frg_out_if.source     rsp_o
);

  localparam int CmpW = (LEN_BITS > 16) ? LEN_BITS : 16;
  localparam logic [frg_pkg::HdrCntBits-1:0] HdrLast =
    frg_pkg::HdrCntBits'(frg_pkg::HeaderBytes - 1);

  frg_pkg::back_state_e state_q, state_d;
  logic [frg_pkg::HdrCntBits-1:0] hcnt_q, hcnt_d;
  logic                 active_q, active_d;
  logic [31:0]          session_q, session_d;
  logic [15:0]          packet_q, packet_d;
  logic [7:0]           total_q, total_d;
  logic [7:0]           next_q, next_d;
  logic [LEN_BITS-1:0]  msg_left_q, msg_left_d;
  logic [15:0]          frag_left_q, frag_left_d;
  logic [15:0]          mss_q, mss_d;

  // Output register
  logic                 rsp_valid_q, rsp_valid_d;
  frg_pkg::kind_e       kind_q, kind_d;
  logic [7:0]           byte_q, byte_d;
  logic [7:0]           idx_q, idx_d;
  logic                 fend_q, fend_d;
  frg_pkg::status_e     status_q, status_d;
  logic                 last_q, last_d;

  logic                 emit_ok;
  logic                 is_empty;
  logic                 hdr_done;
  logic                 open_frag;
  logic                 do_payload;
  logic [7:0]           hdr_byte;
  logic [15:0]          fl_dec;
  logic [LEN_BITS-1:0]  ml_dec;
  logic [CmpW-1:0]      ml_ext;
  logic [15:0]          chunk;

  assign emit_ok   = !rsp_valid_q || rsp_o.ready;
  assign is_empty  = (head_cmd_i.cmd == frg_pkg::CMD_EMPTY);
  assign hdr_done  = (hcnt_q == HdrLast);
  assign open_frag = (frag_left_q == 16'd0);
  assign do_payload =
    emit_ok && (((state_q == frg_pkg::BS_IDLE) && head_valid_i &&
                 (head_cmd_i.cmd == frg_pkg::CMD_BYTE) && active_q && !open_frag) ||
                (state_q == frg_pkg::BS_DATA));

  assign fl_dec = frag_left_q - 16'd1;
  assign ml_dec = msg_left_q - LEN_BITS'(1);
  // Bytes in the fragment about to open
  assign ml_ext = CmpW'(msg_left_q);
  assign chunk  = (ml_ext < CmpW'(mss_q)) ? ml_ext[15:0] : mss_q;

  // Header byte, big-endian fields
  always_comb begin
    unique case (hcnt_q)
      4'd0:    hdr_byte = session_q[31:24];
      4'd1:    hdr_byte = session_q[23:16];
      4'd2:    hdr_byte = session_q[15:8];
      4'd3:    hdr_byte = session_q[7:0];
      4'd4:    hdr_byte = packet_q[15:8];
      4'd5:    hdr_byte = packet_q[7:0];
      4'd7:    hdr_byte = next_q;
      4'd8:    hdr_byte = total_q;
      default: hdr_byte = 8'h00;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frg_pkg::BS_IDLE: begin
        if (head_valid_i && emit_ok) begin
          if (is_empty) begin
            state_d = frg_pkg::BS_HEADER;
          end else if ((head_cmd_i.cmd == frg_pkg::CMD_BYTE) && active_q && open_frag) begin
            state_d = frg_pkg::BS_HEADER;
          end
        end
      end
      frg_pkg::BS_HEADER: begin
        if (emit_ok && hdr_done) begin
          state_d = is_empty ? frg_pkg::BS_IDLE : frg_pkg::BS_DATA;
        end
      end
      frg_pkg::BS_DATA: begin
        if (emit_ok) begin
          state_d = frg_pkg::BS_IDLE;
        end
      end
      default: state_d = frg_pkg::BS_IDLE;
    endcase
  end

  // Outputs and message state
  always_comb begin
    pop_o       = 1'b0;
    hcnt_d      = hcnt_q;
    active_d    = active_q;
    session_d   = session_q;
    packet_d    = packet_q;
    total_d     = total_q;
    next_d      = next_q;
    msg_left_d  = msg_left_q;
    frag_left_d = frag_left_q;
    mss_d       = mss_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    kind_d      = kind_q;
    byte_d      = byte_q;
    idx_d       = idx_q;
    fend_d      = fend_q;
    status_d    = status_q;
    last_d      = last_q;

    unique case (state_q)
      frg_pkg::BS_IDLE: begin
        if (head_valid_i && emit_ok) begin
          unique case (head_cmd_i.cmd)
            frg_pkg::CMD_ERROR: begin
              active_d    = 1'b0;
              pop_o       = 1'b1;
              rsp_valid_d = 1'b1;
              kind_d      = frg_pkg::KIND_STATUS;
              byte_d      = 8'd0;
              idx_d       = 8'd0;
              fend_d      = 1'b0;
              status_d    = head_cmd_i.status;
              last_d      = 1'b1;
            end
            frg_pkg::CMD_START: begin
              active_d    = 1'b1;
              session_d   = head_cmd_i.session;
              packet_d    = head_cmd_i.packet;
              total_d     = head_cmd_i.nfrags;
              next_d      = 8'd0;
              msg_left_d  = head_cmd_i.len[LEN_BITS-1:0];
              frag_left_d = 16'd0;
              mss_d       = head_cmd_i.mss;
              pop_o       = 1'b1;
              rsp_valid_d = 1'b1;
              kind_d      = frg_pkg::KIND_STATUS;
              byte_d      = 8'd0;
              idx_d       = 8'd0;
              fend_d      = 1'b0;
              status_d    = frg_pkg::ST_OK;
              last_d      = 1'b1;
            end
            frg_pkg::CMD_EMPTY: begin
              // One empty fragment: header only
              active_d    = 1'b0;
              session_d   = head_cmd_i.session;
              packet_d    = head_cmd_i.packet;
              total_d     = 8'd1;
              next_d      = 8'd0;
              msg_left_d  = '0;
              frag_left_d = 16'd0;
              hcnt_d      = '0;
            end
            frg_pkg::CMD_BYTE: begin
              if (!active_q) begin
                pop_o       = 1'b1;
                rsp_valid_d = 1'b1;
                kind_d      = frg_pkg::KIND_STATUS;
                byte_d      = 8'd0;
                idx_d       = 8'd0;
                fend_d      = 1'b0;
                status_d    = frg_pkg::ST_STRAY;
                last_d      = 1'b1;
              end else if (open_frag) begin
                frag_left_d = chunk;
                hcnt_d      = '0;
              end
            end
            default: ;
          endcase
        end
      end
      frg_pkg::BS_HEADER: begin
        if (emit_ok) begin
          rsp_valid_d = 1'b1;
          kind_d      = frg_pkg::KIND_HEADER;
          byte_d      = hdr_byte;
          idx_d       = next_q;
          fend_d      = hdr_done && is_empty;
          status_d    = frg_pkg::ST_OK;
          last_d      = hdr_done && is_empty;
          hcnt_d      = hdr_done ? '0 : hcnt_q + frg_pkg::HdrCntBits'(1);
          if (hdr_done && is_empty) begin
            next_d = 8'd1;
            pop_o  = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // Payload byte pass-through
    if (do_payload) begin
      pop_o       = 1'b1;
      rsp_valid_d = 1'b1;
      kind_d      = frg_pkg::KIND_PAYLOAD;
      byte_d      = head_cmd_i.data;
      idx_d       = next_q;
      fend_d      = (fl_dec == 16'd0);
      status_d    = frg_pkg::ST_OK;
      last_d      = 1'b1;
      frag_left_d = fl_dec;
      msg_left_d  = ml_dec;
      if (fl_dec == 16'd0) begin
        next_d = next_q + 8'd1;
      end
      if (ml_dec == '0) begin
        active_d    = 1'b0;
        frag_left_d = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= frg_pkg::BS_IDLE;
      hcnt_q      <= '0;
      active_q    <= 1'b0;
      session_q   <= 32'd0;
      packet_q    <= 16'd0;
      total_q     <= 8'd0;
      next_q      <= 8'd0;
      msg_left_q  <= '0;
      frag_left_q <= 16'd0;
      mss_q       <= 16'd0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hcnt_q      <= hcnt_d;
      active_q    <= active_d;
      session_q   <= session_d;
      packet_q    <= packet_d;
      total_q     <= total_d;
      next_q      <= next_d;
      msg_left_q  <= msg_left_d;
      frag_left_q <= frag_left_d;
      mss_q       <= mss_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    byte_q   <= byte_d;
    idx_q    <= idx_d;
    fend_q   <= fend_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.kind       = kind_q;
  assign rsp_o.out_byte   = byte_q;
  assign rsp_o.frag_index = idx_q;
  assign rsp_o.frag_end   = fend_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.last       = last_q;

endmodule

/* rtl/message_fragmenter_framer_unit.sv */
// Top level of the message fragmenter and framer.
//
//   channel      dir  handshake        payload
//   req_i        in   valid / ready    op, sess_id, pkt_id, msg_len, data_byte
//   rsp_o        out  valid / ready    kind, out_byte, frag_index, frag_end, status, last
//   cfg_we_i     in   write enable     cfg_wdata_i: fragment payload size
//
// A payload byte inside an open fragment goes through the front and then the back;
// back to back such bytes stream at one per cycle while rsp_o.ready stays high. A
// byte that opens a fragment holds the back for a setup step, nine header bytes,
// then the byte. A start holds the front for a check, an 8-step restoring divide,
// one quotient bit per cycle, and then the push. A two-entry request queue lets
// the front take new requests while the back still emits. Reset clears all
// control state at once; there is no clearing pass. Results wait in an output
// register while rsp_o.ready is low.
module message_fragmenter_framer_unit #(
  parameter int LEN_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frg_in_if.sink      req_i,
  frg_out_if.source   rsp_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0]   mss_q;
  logic          push;
  frg_pkg::cmd_t push_cmd;
  logic          full;
  logic          head_valid;
  frg_pkg::cmd_t head_cmd;
  logic          pop;

  // Fragment payload size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mss_q <= frg_pkg::MssReset;
    end else if (cfg_we_i) begin
      mss_q <= cfg_wdata_i;
    end
  end

  frg_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .mss_i      (mss_q),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  frg_cmd_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  frg_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .rsp_o        (rsp_o)
  );

endmodule

/* sim/tb_message_fragmenter_framer_unit.sv */
// Testbench of the message fragmenter and framer: directed cases, then random traffic.
`timescale 1ns / 1ps

module tb_message_fragmenter_framer_unit;

  localparam int LenBits    = 24;
  localparam int CycleLimit = 200000;
  localparam int SettleCyc  = 16;

  // One expected response of the block
  typedef struct {
    frg_pkg::kind_e   kind;
    logic [7:0]       data;
    logic [7:0]       frag_idx;
    logic             frag_end;
    frg_pkg::status_e status;
    logic             is_last;
  } frame_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [15:0] cfg_wdata_i;

  frg_in_if #(.LEN_BITS(LenBits)) req_if ();
  frg_out_if rsp_if ();

  message_fragmenter_framer_unit #(
    .LEN_BITS(LenBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Predicted responses, oldest first
  frame_rsp_t framed_out_q[$];

  // Fragmenter state as the testbench sees it
  logic [15:0] mss_cfg;
  logic [15:0] mss_live;
  logic        msg_open;
  logic [31:0] sess_reg;
  logic [15:0] pkt_reg;
  logic [7:0]  frags_total;
  logic [7:0]  frag_cursor;
  logic [23:0] msg_remaining;
  logic [15:0] frag_remaining;

  int mismatches;
  int cycles;
  int idle_pct;
  int stall_pct;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR @%0t: %s", $realtime, what);
  endtask

  function automatic void push_status(frg_pkg::status_e st);
    framed_out_q.push_back('{frg_pkg::KIND_STATUS, 8'h00, 8'h00, 1'b0, st, 1'b1});
  endfunction

  // Nine header bytes of fragment frag_cursor
  function automatic void push_header(logic ends_frag, logic ends_req);
    logic [7:0] hdr [frg_pkg::HeaderBytes];
    logic       fin;
    hdr[0] = sess_reg[31:24];
    hdr[1] = sess_reg[23:16];
    hdr[2] = sess_reg[15:8];
    hdr[3] = sess_reg[7:0];
    hdr[4] = pkt_reg[15:8];
    hdr[5] = pkt_reg[7:0];
    hdr[6] = 8'h00;
    hdr[7] = frag_cursor;
    hdr[8] = frags_total;
    for (int i = 0; i < frg_pkg::HeaderBytes; i++) begin
      fin = (i == frg_pkg::HeaderBytes - 1);
      framed_out_q.push_back('{frg_pkg::KIND_HEADER, hdr[i], frag_cursor, fin & ends_frag,
                               frg_pkg::ST_OK, fin & ends_req});
    end
  endfunction

  // Expected responses of one accepted request
  function automatic void frame_request(frg_pkg::op_e op, logic [31:0] sid,
                                        logic [15:0] pid, logic [23:0] len,
                                        logic [7:0] data);
    int unsigned nfr;
    int unsigned len_u;
    int unsigned mss_u;
    logic [7:0]  idx;
    logic        fend;
    if (op == frg_pkg::OP_START) begin
      msg_open = 1'b0;
      if (mss_cfg == 16'd0) begin
        push_status(frg_pkg::ST_MSS_ZERO);
        return;
      end
      len_u = len;
      mss_u = mss_cfg;
      nfr = (len_u == 0) ? 1 : (len_u + mss_u - 1) / mss_u;
      if (nfr > 255) begin
        push_status(frg_pkg::ST_TOO_MANY);
        return;
      end
      sess_reg       = sid;
      pkt_reg        = pid;
      frags_total    = 8'(nfr);
      frag_cursor    = 8'd0;
      msg_remaining  = len;
      frag_remaining = 16'd0;
      mss_live       = mss_cfg;
      if (len == 24'd0) begin
        push_header(1'b1, 1'b1);
        frag_cursor = 8'd1;
        return;
      end
      msg_open = 1'b1;
      push_status(frg_pkg::ST_OK);
    end else if (!msg_open) begin
      push_status(frg_pkg::ST_STRAY);
    end else begin
      idx = frag_cursor;
      // A byte that opens a fragment brings its header along
      if (frag_remaining == 16'd0) begin
        frag_remaining = (msg_remaining < mss_live) ? msg_remaining[15:0] : mss_live;
        push_header(1'b0, 1'b0);
      end
      frag_remaining--;
      msg_remaining--;
      fend = (frag_remaining == 16'd0);
      framed_out_q.push_back('{frg_pkg::KIND_PAYLOAD, data, idx, fend, frg_pkg::ST_OK,
                               1'b1});
      if (fend) frag_cursor++;
      if (msg_remaining == 24'd0) begin
        msg_open       = 1'b0;
        frag_remaining = 16'd0;
      end
    end
  endfunction

  // Response checker
  always @(posedge clk_i) begin
    frame_rsp_t e;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (framed_out_q.size() == 0) begin
        report_mismatch($sformatf("unexpected response kind %0d byte %02h",
                                  rsp_if.kind, rsp_if.out_byte));
      end else begin
        e = framed_out_q.pop_front();
        if (rsp_if.kind !== e.kind)
          report_mismatch($sformatf("kind %0d, want %0d", rsp_if.kind, e.kind));
        if (rsp_if.out_byte !== e.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", rsp_if.out_byte, e.data));
        if (rsp_if.frag_index !== e.frag_idx)
          report_mismatch($sformatf("frag_index %0d, want %0d", rsp_if.frag_index,
                                    e.frag_idx));
        if (rsp_if.frag_end !== e.frag_end)
          report_mismatch($sformatf("frag_end %b, want %b", rsp_if.frag_end, e.frag_end));
        if (rsp_if.status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, e.status));
        if (rsp_if.last !== e.is_last)
          report_mismatch($sformatf("last %b, want %b", rsp_if.last, e.is_last));
      end
    end
  end

  // Offer one request; valid stays high after acceptance unless the next call idles
  task automatic push_req(frg_pkg::op_e op, logic [31:0] sid, logic [15:0] pid,
                          logic [23:0] len, logic [7:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.op        <= op;
    req_if.sess_id   <= sid;
    req_if.pkt_id    <= pid;
    req_if.msg_len   <= len;
    req_if.data_byte <= data;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    frame_request(op, sid, pid, len, data);
  endtask

  task automatic send_start(logic [31:0] sid, logic [15:0] pid, logic [23:0] len);
    push_req(frg_pkg::OP_START, sid, pid, len, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(logic [7:0] data);
    push_req(frg_pkg::OP_BYTE, $urandom, 16'($urandom_range(0, 65535)), 24'($urandom),
             data);
  endtask

  // Stop sending and let every predicted response come out
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (framed_out_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_mss(logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mss_cfg = value;
  endtask

  // Zero-length message under the reset fragment size
  task automatic test_empty_message();
    send_start(32'hFFFF_FFFF, 16'hFFFF, 24'd0);
    wait_drained();
  endtask

  task automatic test_stray_byte();
    send_byte(8'h5A);
    wait_drained();
  endtask

  // One fragment of three bytes
  task automatic test_short_message();
    send_start(32'h0123_4567, 16'h89AB, 24'd3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    wait_drained();
  endtask

  // Three fragments of two, two and one byte
  task automatic test_multi_fragment();
    write_mss(16'd2);
    send_start(32'hDEAD_BEEF, 16'h1234, 24'd5);
    for (int i = 0; i < 5; i++) send_byte(8'(8'h10 + i));
    wait_drained();
  endtask

  task automatic test_zero_mss();
    write_mss(16'd0);
    send_start(32'h1111_2222, 16'h3333, 24'd7);
    send_start(32'h4444_5555, 16'h6666, 24'd0);
    wait_drained();
  endtask

  // Fragment count at and over 255, open message abandoned by a new start
  task automatic test_fragment_limit();
    write_mss(16'd1);
    send_start(32'hCAFE_0001, 16'h0001, 24'd256);
    send_start(32'hCAFE_0002, 16'h0002, 24'd255);
    send_byte(8'h3C);
    send_byte(8'hC3);
    send_start(32'hCAFE_0003, 16'h0003, 24'd0);
    wait_drained();
    write_mss(16'hFFFF);
    send_start(32'h8000_0001, 16'h8001, 24'hFF_FFFF);
    send_start(32'h7FFF_FFFE, 16'h7FFE, 24'd16711425);
    send_byte(8'h81);
    send_start(32'h0000_0000, 16'h0000, 24'd1);
    send_byte(8'h7E);
    wait_drained();
  endtask

  // Mostly whole messages, some cut short, stray bytes and huge lengths
  task automatic test_random_traffic(int sender_idle, int rx_stall, logic [15:0] mss,
                                     int n_items);
    int  sent;
    int  len;
    int  cut;
    int  roll;
    bit  paused;
    idle_pct  = sender_idle;
    stall_pct = rx_stall;
    write_mss(mss);
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      // Once per phase the sender waits for the block to empty out
      if (!paused && sent >= n_items / 2) begin
        paused = 1'b1;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        len = $urandom_range(0, 20);
        cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, len) : len;
        send_start($urandom, 16'($urandom_range(0, 65535)), 24'(len));
        sent++;
        for (int k = 0; k < cut; k++) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end else if (roll < 80) begin
        send_byte(8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_start($urandom, 16'($urandom_range(0, 65535)), 24'($urandom));
        sent++;
        cut = $urandom_range(0, 3);
        for (int k = 0; k < cut; k++) begin
          send_byte(8'($urandom_range(0, 255)));
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  // Test sequence
  initial begin
    mismatches     = 0;
    cycles         = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    mss_cfg        = frg_pkg::MssReset;
    mss_live       = 16'd0;
    msg_open       = 1'b0;
    sess_reg       = 32'd0;
    pkt_reg        = 16'd0;
    frags_total    = 8'd0;
    frag_cursor    = 8'd0;
    msg_remaining  = 24'd0;
    frag_remaining = 16'd0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= 16'd0;
    req_if.valid     <= 1'b0;
    req_if.op        <= frg_pkg::OP_START;
    req_if.sess_id   <= 32'd0;
    req_if.pkt_id    <= 16'd0;
    req_if.msg_len   <= '0;
    req_if.data_byte <= 8'd0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_stray_byte();
    test_short_message();
    test_multi_fragment();
    test_zero_mss();
    test_fragment_limit();
    test_random_traffic(0, 0, 16'd3, 45);
    test_random_traffic(78, 0, 16'd1, 45);
    test_random_traffic(0, 78, 16'd7, 45);
    test_random_traffic(22, 22, 16'($urandom_range(2, 16)), 45);

    if (framed_out_q.size() != 0)
      report_mismatch($sformatf("%0d responses never came", framed_out_q.size()));
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
